FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define FTACH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, disabled while reset is high.
`define FTACH_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/ftach_pkg.sv
// Types and constants shared by the fan tachometer period meter.
package ftach_pkg;

  localparam int unsigned NUM_W     = 21;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned FAN_IDX_W = 2;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [NUM_W-1:0] RATE_RESET = 21'd1406470;

  typedef enum logic [0:0] {
    REG_STRETCH = 1'b0,
    REG_RATE    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } ctl_state_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WH1  = 5'b00010,
    PH_WL1  = 5'b00100,
    PH_WH2  = 5'b01000,
    PH_WL2  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               start_measure;
    logic               timeout;
    logic [LEVEL_W-1:0] tach_levels;
  } in_item_t;

  typedef struct packed {
    logic [FAN_IDX_W-1:0] fan_index;
    logic                 busy_res;
    logic                 force_full_drive;
    logic                 done_res;
    logic [RPM_W-1:0]     rpm_value;
  } out_item_t;

endpackage

FILE: rtl/ftach_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module ftach_div #(
  parameter int unsigned DW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ftach_pkg::NUM_W-1:0]   dividend,
  input  logic [DW-1:0]                 divisor,
  output logic                          done,
  output logic [ftach_pkg::NUM_W-1:0]   quotient
);

  logic                                busy;
  logic [ftach_pkg::STEP_W-1:0]        steps;
  logic [DW-1:0]                       rem;
  logic [DW-1:0]                       dvsr;
  logic [ftach_pkg::NUM_W-1:0]         q;
  logic [DW:0]                         shifted;
  logic [DW+1:0]                       diff;
  logic                                ge;
  logic [DW-1:0]                       rem_next;

  assign shifted  = {rem, q[ftach_pkg::NUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvsr};
  assign ge       = ~diff[DW+1];
  assign rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= ftach_pkg::STEP_W'(ftach_pkg::NUM_W);
        rem   <= '0;
        dvsr  <= divisor;
        q     <= dividend;
      end else if (busy) begin
        rem   <= rem_next;
        q     <= {q[ftach_pkg::NUM_W-2:0], ge};
        steps <= steps - ftach_pkg::STEP_W'(1);
        if (steps == ftach_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/fan_tach_period_rpm_meter_core.sv
// Fan tachometer period meter: edge tracking, capture and rpm store around a serial divider.
// An ordinary tick: result registered in the push state once the output is free, next request accepted after hand-over.
// The tick that closes a measurement runs the 21-step serial divider: result valid
// after the divide and push states, next request accepted after the hand-over.
// The output register holds a result while the next item is accepted.
// Synchronous active-high reset: idle, fan 0, counter 0, all stored rpm 0, registers reset.
module fan_tach_period_rpm_meter_core #(
  parameter int unsigned FAN_COUNT    = 4,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ftach_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ftach_pkg::out_item_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ftach_pkg::APB_AW-1:0]      paddr,
  input  logic [ftach_pkg::APB_DW-1:0]      pwdata,
  output logic [ftach_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int unsigned FB  = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
  localparam int unsigned FEW = FB + 2;

  ftach_pkg::ctl_state_t                state;
  ftach_pkg::phase_t                    phase;
  ftach_pkg::phase_t                    phase_next;
  logic [FB-1:0]                        sel_fan;
  logic [FB-1:0]                        sel_fan_next;
  logic [COUNTER_BITS-1:0]              tick_count;
  logic [COUNTER_BITS-1:0]              first_capture;
  logic [ftach_pkg::RPM_W-1:0]          rpm_store [FAN_COUNT];
  logic [ftach_pkg::LEVEL_W-1:0]        stretch_mask;
  logic [ftach_pkg::NUM_W-1:0]          rate_numerator;
  logic                                 done_flag;
  logic                                 done_next;
  logic                                 clear_rpm;
  logic                                 capture;
  logic                                 div_go;
  logic                                 div_done;
  logic [ftach_pkg::NUM_W-1:0]          div_q;
  logic [ftach_pkg::RPM_W-1:0]          rpm_sat;
  logic                                 accept;
  logic                                 push;
  logic                                 cfg_write;
  ftach_pkg::reg_idx_t                  cfg_idx;
  logic [FEW-1:0]                       fan_ext;
  logic                                 fan_in_range;
  logic                                 pin;
  logic                                 busy;
  ftach_pkg::out_item_t                 result;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = ftach_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      ftach_pkg::REG_STRETCH:
        prdata = ftach_pkg::APB_DW'(stretch_mask);
      ftach_pkg::REG_RATE:
        prdata = ftach_pkg::APB_DW'(rate_numerator);
      default:
        prdata = '0;
    endcase
  end

  assign in_ready = (state == ftach_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;
  // Hand over once the output register is free or being drained.
  assign push     = (state == ftach_pkg::ST_PUSH) & (~out_valid | out_ready);

  // Pins and stretch bits above the 4-bit fields read as zero.
  assign fan_ext      = {2'b00, sel_fan};
  assign fan_in_range = (fan_ext < FEW'(ftach_pkg::LEVEL_W));
  assign pin          = fan_in_range ? in_data.tach_levels[fan_ext[1:0]] : 1'b0;

  always_comb begin
    phase_next   = phase;
    sel_fan_next = sel_fan;
    done_next    = 1'b0;
    clear_rpm    = 1'b0;
    capture      = 1'b0;
    div_go       = 1'b0;
    if (phase == ftach_pkg::PH_IDLE) begin
      if (in_data.start_measure) begin
        sel_fan_next = (sel_fan == FB'(FAN_COUNT - 1)) ? '0 : sel_fan + FB'(1);
        clear_rpm    = 1'b1;
        phase_next   = ftach_pkg::PH_WH1;
      end
    end else if (in_data.timeout) begin
      phase_next = ftach_pkg::PH_IDLE;
      done_next  = 1'b1;
    end else begin
      unique case (phase)
        ftach_pkg::PH_WH1: begin
          if (pin) phase_next = ftach_pkg::PH_WL1;
        end
        ftach_pkg::PH_WL1: begin
          if (!pin) begin
            capture    = 1'b1;
            phase_next = ftach_pkg::PH_WH2;
          end
        end
        ftach_pkg::PH_WH2: begin
          if (pin) phase_next = ftach_pkg::PH_WL2;
        end
        ftach_pkg::PH_WL2: begin
          if (!pin) begin
            phase_next = ftach_pkg::PH_IDLE;
            done_next  = 1'b1;
            div_go     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  ftach_div #(
    .DW (COUNTER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept & div_go),
    .dividend (rate_numerator),
    .divisor  (tick_count - first_capture),
    .done     (div_done),
    .quotient (div_q)
  );

  assign rpm_sat = (|div_q[ftach_pkg::NUM_W-1:ftach_pkg::RPM_W]) ? '1
                                                                 : div_q[ftach_pkg::RPM_W-1:0];

  assign busy                    = (phase != ftach_pkg::PH_IDLE);
  assign result.fan_index        = fan_ext[1:0];
  assign result.busy_res         = busy;
  assign result.force_full_drive = busy & fan_in_range & stretch_mask[fan_ext[1:0]];
  assign result.done_res         = done_flag;
  assign result.rpm_value        = rpm_store[sel_fan];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ftach_pkg::ST_IDLE;
      phase          <= ftach_pkg::PH_IDLE;
      sel_fan        <= '0;
      tick_count     <= '0;
      stretch_mask   <= '0;
      rate_numerator <= ftach_pkg::RATE_RESET;
      done_flag      <= 1'b0;
      out_valid      <= 1'b0;
      for (int i = 0; i < FAN_COUNT; i++) begin
        rpm_store[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx)
          ftach_pkg::REG_STRETCH:
            stretch_mask <= pwdata[ftach_pkg::LEVEL_W-1:0];
          ftach_pkg::REG_RATE:
            rate_numerator <= pwdata[ftach_pkg::NUM_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ftach_pkg::ST_IDLE: begin
          if (accept) begin
            phase      <= phase_next;
            sel_fan    <= sel_fan_next;
            tick_count <= tick_count + COUNTER_BITS'(1);
            done_flag  <= done_next;
            if (capture) first_capture <= tick_count;
            if (clear_rpm) rpm_store[sel_fan_next] <= '0;
            state <= div_go ? ftach_pkg::ST_DIV : ftach_pkg::ST_PUSH;
          end
        end
        ftach_pkg::ST_DIV: begin
          if (div_done) begin
            rpm_store[sel_fan] <= rpm_sat;
            state              <= ftach_pkg::ST_PUSH;
          end
        end
        ftach_pkg::ST_PUSH: begin
          if (push) begin
            out_data <= result;
            state    <= ftach_pkg::ST_IDLE;
          end
        end
        default: state <= ftach_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ftach_chk.sv
// Port-level checker for the fan tachometer period meter, bound to the top level.
`include "assert_macros.svh"

module ftach_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input ftach_pkg::out_item_t          out_data
);

  `FTACH_ASSERT(a_drive_needs_busy,
                !out_valid || !out_data.force_full_drive || out_data.busy_res,
                "full drive requested while not measuring")
  `FTACH_ASSERT(a_done_not_busy,
                !out_valid || !out_data.done_res || !out_data.busy_res,
                "done and busy shown together")
  `FTACH_ASSERT_IMPL(a_out_hold,
                     out_valid && !out_ready,
                     out_valid && $stable(out_data),
                     "stalled result dropped or changed")

endmodule

bind fan_tach_period_rpm_meter_core ftach_chk u_ftach_chk (.*);
